>>> rtl/pic_pkg.sv
// Package for the image checksum engine: field widths and file layout constants.
// No dependencies; used by the channel interfaces and pe_image_checksum.
package pic_pkg;

	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int SUM_W  = 16;
	localparam int CNT_W  = 32;
	localparam int CSUM_W = 32;
	localparam int SEEN_W = 3;

	// File byte position of the header offset, and its displacement to the checksum field
	localparam logic [CNT_W-1:0] OFFSET_POS  = 32'h0000_003C;
	localparam logic [CNT_W-1:0] FIELD_START = 32'h0000_0040;
	localparam logic [CNT_W-1:0] FIELD_DISP  = 32'h0000_0058;
	localparam logic [CNT_W-1:0] FIELD_LEN   = 32'h0000_0004;
	localparam logic [SEEN_W-1:0] SEEN_FULL  = 3'd4;

endpackage

>>> rtl/pic_word_if.sv
// Input channel of the image checksum engine: one file word per item.
// Depends on pic_pkg.
interface pic_word_if;
	logic                          valid;
	logic                          ready;
	logic [pic_pkg::WORD_W-1:0]    data_word;
	logic                          last_word;
	logic                          tail_single_byte;

	modport source (output valid, output data_word, output last_word,
		output tail_single_byte, input ready);
	modport sink (input valid, input data_word, input last_word,
		input tail_single_byte, output ready);
endinterface

>>> rtl/pic_result_if.sv
// Result channel of the image checksum engine: stored and computed checksums.
// Depends on pic_pkg.
interface pic_result_if;
	logic                          valid;
	logic                          ready;
	logic [pic_pkg::CSUM_W-1:0]    header_checksum;
	logic [pic_pkg::CSUM_W-1:0]    image_checksum;
	logic                          header_found;

	modport source (output valid, output header_checksum, output image_checksum,
		output header_found, input ready);
	modport sink (input valid, input header_checksum, input image_checksum,
		input header_found, output ready);
endinterface

>>> rtl/pe_image_checksum.sv
// Image checksum engine, top level. Uses pic_pkg, pic_word_if and pic_result_if.
// Single module: input register, running state, end-of-file snapshot, result register.
//
// Takes one 16-bit little-endian file word per cycle, save for the stall below,
// and keeps an end-around-carry sum, the byte count, the header offset (bytes
// 0x3C..0x3F) and the stored checksum found at offset + 0x58. The word flagged last
// gives one result: the stored checksum, the computed checksum (sum with the stored
// halves removed, plus the file length) and header_found, set only when all four
// field bytes lay inside the file. Words flow on while a result waits to be taken.
// A result passes through the input register, the snapshot and the result register
// after its last word is taken. A last word waits in the input register only while
// the previous file's snapshot is held behind a result that has not been taken.
// All state clears after each last word.
module pe_image_checksum (
	input logic           clk,
	input logic           arst_n,
	pic_word_if.sink      words,
	pic_result_if.source  result
);

	// Input register
	logic                          valid_s1;
	logic [pic_pkg::WORD_W-1:0]    word_s1;
	logic                          last_s1;
	logic                          single_s1;

	// Running state
	logic [pic_pkg::SUM_W-1:0]     sum_q;
	logic [pic_pkg::CNT_W-1:0]     count_q;
	logic [pic_pkg::CNT_W-1:0]     offset_q;
	logic [pic_pkg::CSUM_W-1:0]    stored_q;
	logic [pic_pkg::SEEN_W-1:0]    seen_q;

	// End-of-file snapshot
	logic                          valid_s2;
	logic [pic_pkg::SUM_W-1:0]     sum_s2;
	logic [pic_pkg::CNT_W-1:0]     count_s2;
	logic [pic_pkg::CSUM_W-1:0]    stored_s2;
	logic                          found_s2;

	// Result register
	logic                          out_valid_q;
	logic [pic_pkg::CSUM_W-1:0]    header_q;
	logic [pic_pkg::CSUM_W-1:0]    image_q;
	logic                          found_q;

	logic                          s1_go;
	logic                          s1_take;
	logic                          s2_go;
	logic                          in_take;

	logic [pic_pkg::WORD_W-1:0]    w;
	logic [pic_pkg::BYTE_W-1:0]    b0;
	logic [pic_pkg::BYTE_W-1:0]    b1;
	logic [pic_pkg::SUM_W:0]       sum_wide;
	logic [pic_pkg::SUM_W-1:0]     sum_next;
	logic [pic_pkg::CNT_W-1:0]     count_next;
	logic [pic_pkg::CNT_W-1:0]     pos1;
	logic [pic_pkg::CNT_W-1:0]     offset_next;
	logic [pic_pkg::CNT_W-1:0]     field_pos;
	logic [pic_pkg::CNT_W-1:0]     d0;
	logic [pic_pkg::CNT_W-1:0]     d1;
	logic                          hit0;
	logic                          hit1;
	logic [pic_pkg::CSUM_W-1:0]    stored_next;
	logic [pic_pkg::SEEN_W-1:0]    seen_sum;
	logic [pic_pkg::SEEN_W-1:0]    seen_next;
	logic [pic_pkg::SUM_W-1:0]     rem_lo;
	logic [pic_pkg::SUM_W-1:0]     rem_hi;

	// Removes one stored half from the sum, borrowing one more when it wraps
	function automatic logic [pic_pkg::SUM_W-1:0] remove_half(
		input logic [pic_pkg::SUM_W-1:0] c,
		input logic [pic_pkg::SUM_W-1:0] h
	);
		logic [pic_pkg::SUM_W-1:0] diff;
		diff = c - h;
		if (c >= h) begin
			remove_half = diff;
		end else begin
			remove_half = diff - pic_pkg::SUM_W'(1);
		end
	endfunction

	// Handshake: a last item waits only while the previous snapshot cannot move on
	assign s1_go   = !last_s1 || !valid_s2 || s2_go;
	assign s1_take = valid_s1 && s1_go;
	assign words.ready = !valid_s1 || s1_go;
	assign in_take = words.valid && words.ready;
	assign s2_go   = !out_valid_q || result.ready;

	// Item bytes; a single tail byte clears the upper byte
	assign w  = single_s1 ? {{pic_pkg::BYTE_W{1'b0}}, word_s1[pic_pkg::BYTE_W-1:0]}
		: word_s1;
	assign b0 = w[pic_pkg::BYTE_W-1:0];
	assign b1 = w[pic_pkg::WORD_W-1:pic_pkg::BYTE_W];

	// End-around-carry sum
	assign sum_wide = {1'b0, sum_q} + {1'b0, w};
	assign sum_next = sum_wide[pic_pkg::SUM_W]
		? (sum_wide[pic_pkg::SUM_W-1:0] + pic_pkg::SUM_W'(1))
		: sum_wide[pic_pkg::SUM_W-1:0];

	// Byte positions: the first byte of a word always sits at an even position
	assign pos1       = count_q + pic_pkg::CNT_W'(1);
	assign count_next = single_s1 ? pos1 : (count_q + pic_pkg::CNT_W'(2));

	// Header offset capture, one lane per byte position
	always_comb begin
		offset_next = offset_q;
		if (count_q >= pic_pkg::OFFSET_POS &&
				count_q <= pic_pkg::OFFSET_POS + pic_pkg::CNT_W'(3)) begin
			offset_next[count_q[1:0]*pic_pkg::BYTE_W +: pic_pkg::BYTE_W] = b0;
		end
		if (!single_s1 && pos1 >= pic_pkg::OFFSET_POS &&
				pos1 <= pic_pkg::OFFSET_POS + pic_pkg::CNT_W'(3)) begin
			offset_next[pos1[1:0]*pic_pkg::BYTE_W +: pic_pkg::BYTE_W] = b1;
		end
	end

	// Stored checksum capture; the offset is complete before any field byte can hit
	assign field_pos = offset_q + pic_pkg::FIELD_DISP;
	assign d0   = count_q - field_pos;
	assign d1   = d0 + pic_pkg::CNT_W'(1);
	assign hit0 = (count_q >= pic_pkg::FIELD_START) && (d0 < pic_pkg::FIELD_LEN);
	assign hit1 = !single_s1 && (pos1 >= pic_pkg::FIELD_START) && (d1 < pic_pkg::FIELD_LEN);

	always_comb begin
		stored_next = stored_q;
		if (hit0) begin
			stored_next[d0[1:0]*pic_pkg::BYTE_W +: pic_pkg::BYTE_W] = b0;
		end
		if (hit1) begin
			stored_next[d1[1:0]*pic_pkg::BYTE_W +: pic_pkg::BYTE_W] = b1;
		end
	end

	// Field byte counter, saturating at four
	assign seen_sum  = seen_q + pic_pkg::SEEN_W'(hit0) + pic_pkg::SEEN_W'(hit1);
	assign seen_next = (seen_sum > pic_pkg::SEEN_FULL) ? pic_pkg::SEEN_FULL : seen_sum;

	// Final checksum from the snapshot
	assign rem_lo = remove_half(sum_s2, stored_s2[pic_pkg::SUM_W-1:0]);
	assign rem_hi = remove_half(rem_lo, stored_s2[pic_pkg::CSUM_W-1:pic_pkg::SUM_W]);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1   <= words.data_word;
			last_s1   <= words.last_word;
			single_s1 <= words.last_word && words.tail_single_byte;
		end
	end

	// Running state; cleared after each last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			offset_q <= '0;
			stored_q <= '0;
			seen_q   <= '0;
		end else if (s1_take) begin
			if (last_s1) begin
				sum_q    <= '0;
				count_q  <= '0;
				offset_q <= '0;
				stored_q <= '0;
				seen_q   <= '0;
			end else begin
				sum_q    <= sum_next;
				count_q  <= count_next;
				offset_q <= offset_next;
				stored_q <= stored_next;
				seen_q   <= seen_next;
			end
		end
	end

	// End-of-file snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_take && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_go) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && last_s1) begin
			sum_s2    <= sum_next;
			count_s2  <= count_next;
			stored_s2 <= stored_next;
			found_s2  <= (seen_next >= pic_pkg::SEEN_FULL);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && valid_s2) begin
			header_q <= stored_s2;
			image_q  <= {{(pic_pkg::CSUM_W-pic_pkg::SUM_W){1'b0}}, rem_hi} + count_s2;
			found_q  <= found_s2;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.header_checksum = header_q;
	assign result.image_checksum  = image_q;
	assign result.header_found    = found_q;

endmodule

>>> dv/tb_pe_image_checksum.sv
// Testbench for pe_image_checksum: streams files as 16-bit words, predicts the
// stored and computed checksums, and checks every result in order.
// Depends on pic_pkg, pic_word_if, pic_result_if and the pe_image_checksum RTL.
`timescale 1ns / 100ps

module tb_pe_image_checksum;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int MAX_WAIT        = 13;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 10;
	localparam int TOTAL_WORDS     = 1050;

	typedef struct packed {
		logic [pic_pkg::CSUM_W-1:0] stored;
		logic [pic_pkg::CSUM_W-1:0] computed;
		logic                       found;
	} checksum_t;

	// Where the stored checksum field sits relative to the file
	typedef enum int {
		FIELD_INSIDE,
		FIELD_AT_START,
		FIELD_AT_END,
		FIELD_CUT,
		FIELD_PAST_END,
		FIELD_EARLY,
		OFFSET_RANDOM,
		NO_HEADER
	} layout_t;

	logic clk;
	logic arst_n;

	pic_word_if   words_ch ();
	pic_result_if result_ch ();

	pe_image_checksum dut (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words_ch),
		.result (result_ch)
	);

	// Predictor state for the file in flight
	logic [pic_pkg::SUM_W-1:0]  sum_acc;
	logic [pic_pkg::CNT_W-1:0]  byte_pos;
	logic [pic_pkg::CNT_W-1:0]  pe_offset;
	logic [pic_pkg::CSUM_W-1:0] field_val;
	logic [pic_pkg::SEEN_W-1:0] field_cnt;

	checksum_t   due_checksums[$];
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	int unsigned words_sent  = 0;
	bit          tx_steady   = 1'b0;
	bit          rx_steady   = 1'b0;
	bit          hold_req    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	task automatic clear_image_state();
		sum_acc   = '0;
		byte_pos  = '0;
		pe_offset = '0;
		field_val = '0;
		field_cnt = '0;
	endtask

	// Offset bytes land at 0x3C..0x3F; field bytes only count from 0x40 upwards
	task automatic capture_byte(input logic [pic_pkg::CNT_W-1:0] pos,
		input logic [pic_pkg::BYTE_W-1:0] b);
		logic [pic_pkg::CNT_W-1:0] d;
		if (pos >= pic_pkg::OFFSET_POS && pos < pic_pkg::OFFSET_POS + pic_pkg::FIELD_LEN) begin
			pe_offset[8*pos[1:0] +: 8] = b;
		end
		d = pos - (pe_offset + pic_pkg::FIELD_DISP);
		if (pos >= pic_pkg::FIELD_START && d < pic_pkg::FIELD_LEN) begin
			field_val[8*d[1:0] +: 8] = b;
			if (field_cnt < pic_pkg::SEEN_FULL) begin
				field_cnt++;
			end
		end
	endtask

	// Take a stored half out of the sum; a borrow costs one more
	function automatic logic [31:0] strip_half(input logic [31:0] c, input logic [15:0] h);
		logic [31:0] diff;
		diff = c - {16'h0, h};
		if (c >= {16'h0, h}) begin
			return diff;
		end
		return {16'h0, diff[15:0]} - 32'd1;
	endfunction

	task automatic fold_word(input logic [pic_pkg::WORD_W-1:0] data, input logic last,
		input logic tail);
		logic [pic_pkg::WORD_W-1:0] w;
		logic [pic_pkg::SUM_W:0]    s;
		logic                       single;
		logic [31:0]                c;
		checksum_t                  due;
		single = last & tail;
		w = data;
		if (single) begin
			w[15:8] = '0;
		end
		// end-around carry
		s = {1'b0, sum_acc} + w;
		if (s[pic_pkg::SUM_W]) begin
			s = {1'b0, s[pic_pkg::SUM_W-1:0]} + 1'b1;
		end
		sum_acc = s[pic_pkg::SUM_W-1:0];
		capture_byte(byte_pos, w[7:0]);
		byte_pos++;
		if (!single) begin
			capture_byte(byte_pos, w[15:8]);
			byte_pos++;
		end
		if (last) begin
			c = strip_half({16'h0, sum_acc}, field_val[15:0]);
			c = strip_half({16'h0, c[15:0]}, field_val[31:16]);
			due.stored   = field_val;
			due.computed = c + byte_pos;
			due.found    = (field_cnt >= pic_pkg::SEEN_FULL);
			due_checksums.push_back(due);
			clear_image_state();
		end
	endtask

	// Result check, word tracking and stall watchdog
	always @(posedge clk) begin
		checksum_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_checksums.size() == 0) begin
					$display("%0t: unexpected result: header_checksum %h image_checksum %h header_found %b",
						$time, result_ch.header_checksum, result_ch.image_checksum,
						result_ch.header_found);
					mismatches++;
				end else begin
					want = due_checksums.pop_front();
					if (result_ch.header_checksum !== want.stored) begin
						$display("%0t: header_checksum expected %h actual %h",
							$time, want.stored, result_ch.header_checksum);
						mismatches++;
					end
					if (result_ch.image_checksum !== want.computed) begin
						$display("%0t: image_checksum expected %h actual %h",
							$time, want.computed, result_ch.image_checksum);
						mismatches++;
					end
					if (result_ch.header_found !== want.found) begin
						$display("%0t: header_found expected %b actual %b",
							$time, want.found, result_ch.header_found);
						mismatches++;
					end
				end
			end
			if (words_ch.valid && words_ch.ready) begin
				fold_word(words_ch.data_word, words_ch.last_word, words_ch.tail_single_byte);
			end
		end
		if ((words_ch.valid && words_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result side: random stalls per item, plus one long hold-off on request
	initial begin : result_sink
		int unsigned wait_n;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			wait_n = rx_steady ? 0 : $urandom_range(MAX_WAIT, 0);
			if (wait_n > 0) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (wait_n - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	// Offer one word and hold it until taken
	task automatic send_word(input logic [pic_pkg::WORD_W-1:0] data, input logic last,
		input logic tail);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(MAX_WAIT, 0);
		if (gap > 0) begin
			@(negedge clk);
			words_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		words_ch.data_word        <= data;
		words_ch.last_word        <= last;
		words_ch.tail_single_byte <= tail;
		words_ch.valid            <= 1'b1;
		do @(posedge clk); while (!words_ch.ready);
		words_sent++;
	endtask

	// Pack bytes into little-endian words; an odd tail goes out as a single byte
	task automatic send_file(input logic [7:0] img[$]);
		logic [pic_pkg::WORD_W-1:0] data;
		logic                       last;
		logic                       tail;
		logic [7:0]                 junk;
		for (int i = 0; i < img.size(); i += 2) begin
			last = (i + 2 >= img.size());
			junk = $urandom_range(255, 0);
			if (last) begin
				tail = (i + 1 == img.size());
				data = tail ? {junk, img[i]} : {img[i+1], img[i]};
			end else begin
				// tail flag on an inner word must be ignored
				tail = ($urandom_range(3, 0) == 0);
				data = {img[i+1], img[i]};
			end
			send_word(data, last, tail);
		end
	endtask

	// Random file with the header offset chosen to place the checksum field
	task automatic make_image(input layout_t layout, output logic [7:0] img[$]);
		int unsigned               len;
		logic [pic_pkg::CNT_W-1:0] field_pos;
		logic [pic_pkg::CNT_W-1:0] off;
		if (layout == NO_HEADER) begin
			len = ($urandom_range(1, 0) == 0) ? $urandom_range(6, 1) : $urandom_range(63, 1);
		end else if ($urandom_range(7, 0) == 0) begin
			len = $urandom_range(288, 68);
		end else begin
			len = $urandom_range(100, 68);
		end
		img = {};
		for (int i = 0; i < len; i++) begin
			img.push_back($urandom_range(255, 0));
		end
		case (layout)
			FIELD_INSIDE:   field_pos = $urandom_range(len - pic_pkg::FIELD_LEN,
				pic_pkg::FIELD_START);
			FIELD_AT_START: field_pos = pic_pkg::FIELD_START;
			FIELD_AT_END:   field_pos = len - pic_pkg::FIELD_LEN;
			FIELD_CUT:      field_pos = $urandom_range(len - 1, len - 3);
			FIELD_PAST_END: field_pos = len + $urandom_range(512, 0);
			FIELD_EARLY:    field_pos = $urandom_range(pic_pkg::FIELD_START - 1, 0);
			OFFSET_RANDOM:  field_pos = $urandom() + pic_pkg::FIELD_DISP;
			default:        field_pos = $urandom();
		endcase
		off = field_pos - pic_pkg::FIELD_DISP;
		for (int k = 0; k < 4; k++) begin
			if (pic_pkg::OFFSET_POS + k < len) begin
				img[pic_pkg::OFFSET_POS + k] = off[8*k +: 8];
			end
		end
	endtask

	// All-zero and all-one words, carry wrap, single bytes
	task automatic test_word_extremes();
		send_word(16'hFFFF, 1'b1, 1'b0);
		send_word(16'h0000, 1'b1, 1'b0);
		send_word(16'hFFFF, 1'b0, 1'b0);
		send_word(16'hFFFF, 1'b0, 1'b0);
		send_word(16'hFFFF, 1'b1, 1'b0);
		send_word(16'h0001, 1'b0, 1'b0);
		send_word(16'hFFFF, 1'b1, 1'b0);
		send_word(16'hFFFF, 1'b1, 1'b1);
		send_word(16'h00FF, 1'b1, 1'b1);
	endtask

	// Tail flag on inner words, odd-length files
	task automatic test_tail_handling();
		send_word(16'hFFFF, 1'b0, 1'b1);
		send_word(16'h1234, 1'b1, 1'b0);
		send_word(16'h8000, 1'b0, 1'b1);
		send_word(16'h7F80, 1'b0, 1'b0);
		send_word(16'hA5C3, 1'b1, 1'b1);
		send_word(16'h5A00, 1'b1, 1'b1);
	endtask

	// One file per field placement
	task automatic test_header_layouts();
		logic [7:0] img[$];
		for (int l = FIELD_INSIDE; l <= NO_HEADER; l++) begin
			make_image(layout_t'(l), img);
			send_file(img);
		end
	endtask

	// Receiver holds off while short files keep coming, so the input stalls
	task automatic test_backpressure();
		logic [7:0] img[$];
		hold_req  = 1'b1;
		tx_steady = 1'b1;
		for (int f = 0; f < 8; f++) begin
			img = {};
			repeat ($urandom_range(12, 1)) img.push_back($urandom_range(255, 0));
			send_file(img);
		end
		tx_steady = 1'b0;
	endtask

	// Mostly well-formed headers, some broken placements and short noise files
	task automatic test_random_files();
		logic [7:0]  img[$];
		int unsigned pick;
		layout_t     layout;
		while (words_sent < TOTAL_WORDS) begin
			tx_steady = ($urandom_range(9, 0) == 0);
			rx_steady = ($urandom_range(9, 0) == 0);
			pick = $urandom_range(99, 0);
			if (pick < 45)      layout = FIELD_INSIDE;
			else if (pick < 55) layout = FIELD_CUT;
			else if (pick < 62) layout = FIELD_PAST_END;
			else if (pick < 69) layout = FIELD_EARLY;
			else if (pick < 74) layout = OFFSET_RANDOM;
			else if (pick < 77) layout = FIELD_AT_START;
			else if (pick < 80) layout = FIELD_AT_END;
			else                layout = NO_HEADER;
			make_image(layout, img);
			send_file(img);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Sequence of tests, then drain and verdict
	initial begin
		arst_n                     = 1'b0;
		words_ch.valid             = 1'b0;
		words_ch.data_word         = '0;
		words_ch.last_word         = 1'b0;
		words_ch.tail_single_byte  = 1'b0;
		clear_image_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_word_extremes();
		test_tail_handling();
		test_header_layouts();
		test_backpressure();
		test_random_files();

		@(negedge clk);
		words_ch.valid <= 1'b0;
		while (due_checksums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> pe_image_checksum.f
rtl/pic_pkg.sv
rtl/pic_word_if.sv
rtl/pic_result_if.sv
rtl/pe_image_checksum.sv
dv/tb_pe_image_checksum.sv
